FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// needs clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// plain condition checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

FILE: rtl/slf_pkg.sv
// shared types and constants of the substring line filter
// no dependencies
`default_nettype none

package slf_pkg;

  localparam int LINE_BYTES_DEF  = 63;
  localparam int PATTERN_MAX_DEF = 8;

  localparam int BYTE_W   = 8;
  localparam int PLEN_W   = 4;
  localparam int PAT_W    = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  // control from the sequencer to the matcher
  typedef struct packed {
    logic take;   // a non-newline byte enters the line
    logic clear;  // the line closes
  } match_ctl_t;

  // status from the matcher
  typedef struct packed {
    logic found_next; // pattern seen including the byte being taken
    logic match_all;  // empty pattern
  } match_stat_t;

endpackage

`default_nettype wire

FILE: rtl/slf_line_store.sv
// line buffer memory, one write and one registered read port
// uses slf_pkg
`default_nettype none

module slf_line_store #(
  parameter int LINE_BYTES = slf_pkg::LINE_BYTES_DEF,
  parameter int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [slf_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output      logic [slf_pkg::BYTE_W-1:0] rd_data
);
  import slf_pkg::*;

  logic [BYTE_W-1:0] mem [LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slf_matcher.sv
// window of recent bytes and pattern compare for the current line
// uses slf_pkg
`default_nettype none

module slf_matcher #(
  parameter int PATTERN_MAX = slf_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire slf_pkg::match_ctl_t          ctl,
  input  wire logic [slf_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic [PATTERN_MAX*8-1:0]     pattern,
  input  wire logic [slf_pkg::PLEN_W-1:0]   pattern_length,
  output      slf_pkg::match_stat_t         stat
);
  import slf_pkg::*;

  localparam int WIN_W = PATTERN_MAX * 8;
  localparam int SW    = $clog2(PATTERN_MAX + 1);

  logic [WIN_W-1:0]  recent;
  logic [WIN_W-1:0]  recent_next;
  logic [SW-1:0]     seen;
  logic [SW-1:0]     seen_next;
  logic              found;
  logic [PLEN_W-1:0] eff_len;
  logic [PATTERN_MAX:1] hit_n;
  logic              hit;

  always_comb begin
    if (pattern_length > PLEN_W'(PATTERN_MAX)) begin
      eff_len = PLEN_W'(PATTERN_MAX);
    end else begin
      eff_len = pattern_length;
    end
  end

  // newest byte enters at the top
  always_comb begin
    for (int p = 0; p < PATTERN_MAX - 1; p++) begin
      recent_next[p*8 +: 8] = recent[(p+1)*8 +: 8];
    end
    recent_next[(PATTERN_MAX-1)*8 +: 8] = in_byte;
  end

  always_comb begin
    if (seen == SW'(PATTERN_MAX)) begin
      seen_next = seen;
    end else begin
      seen_next = seen + SW'(1);
    end
  end

  // one compare per possible pattern length, the newest m bytes against it
  always_comb begin
    for (int m = 1; m <= PATTERN_MAX; m++) begin
      hit_n[m] = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (j < m) begin
          if (recent_next[(PATTERN_MAX-m+j)*8 +: 8] != pattern[j*8 +: 8]) begin
            hit_n[m] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int m = 1; m <= PATTERN_MAX; m++) begin
      if (eff_len == PLEN_W'(m) && seen_next >= SW'(m)) begin
        hit = hit_n[m];
      end
    end
  end

  assign stat.found_next = ctl.take ? (found | hit) : found;
  assign stat.match_all  = (eff_len == '0);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      recent <= '0;
      seen   <= '0;
      found  <= 1'b0;
    end else if (ctl.take) begin
      recent <= recent_next;
      seen   <= seen_next;
      found  <= found | hit;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/substring_line_filter.sv
// substring_line_filter: passes the lines of a byte stream that hold a fixed pattern
//
// input channel s_*: one text byte per item in s_tdata, s_tlast marks the last byte
// of the stream and closes an unterminated line. output channel m_*: the bytes of
// each matching line followed by a newline that carries m_tlast; m_tuser is set on
// every item of a line that was longer than LINE_BYTES and got cut.
// cfg_*: register 0 holds the pattern bytes (first byte lowest), register 1 the
// pattern length (0 matches every line, values above PATTERN_MAX saturate);
// cfg_ready is always high, write only while the block is idle.
// an ordinary byte is taken whenever s_tready is high. a closing byte of a matching line
// starts a replay from the line memory: the stored bytes are shown in order and then the
// newline, one item per cycle while m_tready is high. input is held off (s_tready low)
// during the replay and opens again as the newline is shown.
// a stalled receiver freezes the output register and the replay behind it.
// reset (rst, synchronous) empties the line and clears the pattern registers.
// uses slf_pkg, slf_matcher, slf_line_store
`default_nettype none

module substring_line_filter #(
  parameter int LINE_BYTES  = slf_pkg::LINE_BYTES_DEF,
  parameter int PATTERN_MAX = slf_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [7:0]                    s_tdata,   // in_byte [7:0]
  input  wire logic                          s_tlast,   // final_req
  // output stream
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [7:0]                    m_tdata,   // out_byte [7:0]
  output      logic                          m_tuser,   // truncated
  output      logic                          m_tlast,   // last
  // register writes
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [slf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [slf_pkg::PAT_W-1:0]     cfg_data
);
  import slf_pkg::*;

  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int CW = $clog2(LINE_BYTES + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPLAY = 2'b10
  } state_t;

  state_t state;

  logic [PATTERN_MAX*8-1:0] pattern;
  logic [PLEN_W-1:0]        pattern_length;

  logic [CW-1:0] line_count;
  logic [CW-1:0] line_count_next;
  logic          overflowed;
  logic          overflowed_next;

  logic [CW-1:0] replay_len;
  logic [CW-1:0] rd_idx;
  logic          replay_trunc;
  logic          rd_valid;
  logic [BYTE_W-1:0] rd_data;

  logic accept, is_nl, take, close, store, emit;
  logic out_free, issue, load_byte, load_nl;

  match_ctl_t  mctl;
  match_stat_t mstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:  pattern        <= cfg_data[PATTERN_MAX*8-1:0];
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_nl    = (s_tdata == NEWLINE);
  assign take     = accept && !is_nl;
  assign close    = accept && (is_nl || s_tlast);
  assign store    = take && (line_count < CW'(LINE_BYTES));

  assign line_count_next = line_count + CW'(store);
  assign overflowed_next = overflowed | (take && !store);

  assign mctl.take  = take;
  assign mctl.clear = close;

  assign emit = close && (mstat.match_all || mstat.found_next);

  slf_matcher #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_matcher (
    .clk            (clk),
    .rst            (rst),
    .ctl            (mctl),
    .in_byte        (s_tdata),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .stat           (mstat)
  );

  // replay pump: one read in flight, output register ahead of it
  assign out_free  = !m_tvalid || m_tready;
  assign issue     = (state == ST_REPLAY) && (rd_idx < replay_len) && (!rd_valid || out_free);
  assign load_byte = rd_valid && out_free;
  assign load_nl   = (state == ST_REPLAY) && !rd_valid && (rd_idx == replay_len) && out_free;

  slf_line_store #(
    .LINE_BYTES(LINE_BYTES),
    .AW(AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (line_count[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (issue),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_count <= '0;
      overflowed <= 1'b0;
      rd_idx     <= '0;
      rd_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (close) begin
            line_count <= '0;
            overflowed <= 1'b0;
            if (emit) begin
              state <= ST_REPLAY;
            end
          end else if (take) begin
            line_count <= line_count_next;
            overflowed <= overflowed_next;
          end
          rd_idx <= '0;
        end
        ST_REPLAY: begin
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (load_nl) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (load_byte) begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      replay_len   <= line_count_next;
      replay_trunc <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_byte || load_nl) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      m_tdata <= rd_data;
      m_tuser <= replay_trunc;
      m_tlast <= 1'b0;
    end else if (load_nl) begin
      m_tdata <= NEWLINE;
      m_tuser <= replay_trunc;
      m_tlast <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slf_checker.sv
// port-level checks for substring_line_filter, bound to the top level
// uses slf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module slf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tuser,
  input wire logic       m_tlast
);
  import slf_pkg::*;

  // stalled item holds
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output item changed")

  // the closing item of a line is always a newline
  `ASSERT_CLK(a_last_is_nl, m_tvalid && m_tlast |-> m_tdata == NEWLINE, "last item is not a newline")

  // line bytes are shown only during a replay, when input is held off
  `ASSERT_CLK(a_replay_blocks, m_tvalid && !m_tlast |-> !s_tready, "input open during replay")

  // a replay ends by loading the closing newline
  `ASSERT_CLK(a_replay_end, $rose(s_tready) |-> m_tvalid && m_tlast, "replay ended without newline")

endmodule

bind substring_line_filter slf_checker u_slf_checker (.*);

`default_nettype wire
